// File: hdl/baro_soc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package baro_soc_pkg;

  localparam int RAW_W       = 24;
  localparam int ADC_BITS    = 24;
  localparam int CAL_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int NUM_STAGES  = 9;

  localparam int DT_W        = CAL_W + 9;
  localparam int MUL_W       = DT_W + CAL_W + 1;
  localparam int DD_W        = 2 * DT_W;
  localparam int T2_W        = DD_W - 31;
  localparam int TEMP_W      = MUL_W - 23 + 1;
  localparam int TC_W        = TEMP_W + 1;
  localparam int SQ_W        = 2 * TC_W;
  localparam int WIDE_W      = 40;
  localparam int LO_W        = WIDE_W / 2;
  localparam int HI_W        = WIDE_W - LO_W;
  localparam int PL_W        = ADC_BITS + LO_W;
  localparam int PH_W        = ADC_BITS + 1 + HI_W;
  localparam int PROD_W      = ADC_BITS + WIDE_W + 1;
  localparam int DIFF_W      = PROD_W - 21 + 1;
  localparam int PRESS_W     = DIFF_W - 15;

  localparam int TEMP_OUT_W  = 15;
  localparam int PRESS_OUT_W = 17;

  localparam logic signed [TEMP_W-1:0] TEMP_REF = TEMP_W'(2000);
  localparam logic signed [TEMP_W-1:0] TEMP_LOW = -TEMP_W'(1500);
  localparam logic signed [TC_W-1:0]   TEMP_MIN = -TC_W'(4000);
  localparam logic signed [TC_W-1:0]   TEMP_MAX = TC_W'(8500);
  localparam logic signed [PRESS_W-1:0] PRESS_MIN = PRESS_W'(1000);
  localparam logic signed [PRESS_W-1:0] PRESS_MAX = PRESS_W'(120000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESSURE_SENSITIVITY = 3'd0,
    REG_PRESSURE_OFFSET      = 3'd1,
    REG_SENS_TEMP_COEFF      = 3'd2,
    REG_OFFSET_TEMP_COEFF    = 3'd3,
    REG_REFERENCE_TEMP       = 3'd4,
    REG_TEMP_COEFF           = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [CAL_W-1:0] pressure_sensitivity;
    logic [CAL_W-1:0] pressure_offset;
    logic [CAL_W-1:0] sens_temp_coeff;
    logic [CAL_W-1:0] offset_temp_coeff;
    logic [CAL_W-1:0] reference_temp;
    logic [CAL_W-1:0] temp_coeff;
  } cal_t;

  typedef struct packed {
    logic [ADC_BITS-1:0]      d1;
    logic signed [TEMP_W-1:0] temp;
    logic signed [WIDE_W-1:0] off;
    logic signed [WIDE_W-1:0] sens;
    logic [T2_W-1:0]          t2;
  } first_t;

  typedef struct packed {
    logic [ADC_BITS-1:0]      d1;
    logic signed [TC_W-1:0]   temp_c;
    logic signed [WIDE_W-1:0] off_c;
    logic signed [WIDE_W-1:0] sens_c;
  } second_t;

endpackage

`default_nettype wire

// File: hdl/baro_soc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module baro_soc_front (
  input  logic                           clk,
  input  logic [2:0]                     en,
  input  logic [baro_soc_pkg::RAW_W-1:0] raw_temp,
  input  logic [baro_soc_pkg::RAW_W-1:0] raw_press,
  input  baro_soc_pkg::cal_t             cal,
  output baro_soc_pkg::first_t           first
);
  import baro_soc_pkg::*;

  logic [ADC_BITS-1:0]      d1_s1;
  logic signed [DT_W-1:0]   dt;
  logic [ADC_BITS-1:0]      d1_s2;
  logic signed [MUL_W-1:0]  p_t;
  logic signed [MUL_W-1:0]  p_o;
  logic signed [MUL_W-1:0]  p_s;
  logic signed [DD_W-1:0]   p_dd;
  logic signed [TEMP_W-1:0] temp_next;
  logic signed [WIDE_W-1:0] off_next;
  logic signed [WIDE_W-1:0] sens_next;
  logic [T2_W-1:0]          t2_next;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d1_s1 <= raw_press[ADC_BITS-1:0];
      dt    <= $signed(DT_W'(raw_temp[ADC_BITS-1:0]))
             - $signed(DT_W'({cal.reference_temp, 8'h00}));
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      d1_s2 <= d1_s1;
      p_t   <= dt * $signed({1'b0, cal.temp_coeff});
      p_o   <= dt * $signed({1'b0, cal.offset_temp_coeff});
      p_s   <= dt * $signed({1'b0, cal.sens_temp_coeff});
      p_dd  <= dt * dt;
    end
  end

  always_comb begin
    temp_next = TEMP_W'(p_t >>> 23) + TEMP_REF;
    off_next  = $signed(WIDE_W'({cal.pressure_offset, 16'h0000})) + WIDE_W'(p_o >>> 7);
    sens_next = $signed(WIDE_W'({cal.pressure_sensitivity, 15'h0000})) + WIDE_W'(p_s >>> 8);
    t2_next   = T2_W'($unsigned(p_dd) >> 31);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      first.d1   <= d1_s2;
      first.temp <= temp_next;
      first.off  <= off_next;
      first.sens <= sens_next;
      first.t2   <= t2_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/baro_soc_second.sv
`timescale 1ns / 1ps
`default_nettype none

module baro_soc_second (
  input  logic                  clk,
  input  logic [1:0]            en,
  input  baro_soc_pkg::first_t  first,
  output baro_soc_pkg::second_t second
);
  import baro_soc_pkg::*;

  logic signed [TC_W-1:0]   a;
  logic signed [TC_W-1:0]   b;
  logic signed [SQ_W-1:0]   sq;
  logic signed [SQ_W-1:0]   sq2;
  logic                     below_ref;
  logic                     below_low;
  first_t                   hold;
  logic [WIDE_W-1:0]        sq_u;
  logic [WIDE_W-1:0]        sq2_u;
  logic [WIDE_W-1:0]        off2;
  logic [WIDE_W-1:0]        sens2;
  logic signed [TC_W-1:0]   temp_c_next;

  always_comb begin
    a = TC_W'($signed(first.temp)) - TC_W'(TEMP_REF);
    b = TC_W'($signed(first.temp)) - TC_W'(TEMP_LOW);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sq        <= a * a;
      sq2       <= b * b;
      below_ref <= $signed(first.temp) < TEMP_REF;
      below_low <= $signed(first.temp) < TEMP_LOW;
      hold      <= first;
    end
  end

  always_comb begin
    sq_u  = WIDE_W'($unsigned(sq));
    sq2_u = WIDE_W'($unsigned(sq2));
    off2  = '0;
    sens2 = '0;
    temp_c_next = TC_W'($signed(hold.temp));
    if (below_ref) begin
      off2  = (sq_u * WIDE_W'(5)) >> 1;
      sens2 = (sq_u * WIDE_W'(5)) >> 2;
      if (below_low) begin
        off2  = off2 + sq2_u * WIDE_W'(7);
        sens2 = sens2 + ((sq2_u * WIDE_W'(11)) >> 1);
      end
      temp_c_next = TC_W'($signed(hold.temp)) - $signed(TC_W'(hold.t2));
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      second.d1     <= hold.d1;
      second.temp_c <= temp_c_next;
      second.off_c  <= $signed(hold.off) - $signed(off2);
      second.sens_c <= $signed(hold.sens) - $signed(sens2);
    end
  end

endmodule

`default_nettype wire

// File: hdl/baro_soc_press.sv
`timescale 1ns / 1ps
`default_nettype none

module baro_soc_press (
  input  logic                                       clk,
  input  logic [3:0]                                 en,
  input  baro_soc_pkg::second_t                      second,
  output logic signed [baro_soc_pkg::TEMP_OUT_W-1:0] temp_centi,
  output logic [baro_soc_pkg::PRESS_OUT_W-1:0]       press_pa,
  output logic                                       saturated
);
  import baro_soc_pkg::*;

  logic [PL_W-1:0]           pl;
  logic signed [PH_W-1:0]    ph;
  logic signed [WIDE_W-1:0]  off_s6;
  logic signed [TC_W-1:0]    temp_s6;
  logic signed [PROD_W-1:0]  prod;
  logic signed [WIDE_W-1:0]  off_s7;
  logic signed [TC_W-1:0]    temp_s7;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [TC_W-1:0]    temp_s8;
  logic signed [PRESS_W-1:0] press;
  logic signed [TC_W-1:0]    temp_cl;
  logic signed [PRESS_W-1:0] press_cl;
  logic                      sat_next;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pl      <= PL_W'(second.d1) * PL_W'(second.sens_c[LO_W-1:0]);
      ph      <= $signed({1'b0, second.d1}) * $signed(second.sens_c[WIDE_W-1:LO_W]);
      off_s6  <= second.off_c;
      temp_s6 <= second.temp_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod    <= (PROD_W'(ph) <<< LO_W) + $signed(PROD_W'(pl));
      off_s7  <= off_s6;
      temp_s7 <= temp_s6;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      diff    <= DIFF_W'(prod >>> 21) - DIFF_W'(off_s7);
      temp_s8 <= temp_s7;
    end
  end

  always_comb begin
    press    = PRESS_W'(diff >>> 15);
    sat_next = 1'b0;
    temp_cl  = temp_s8;
    press_cl = press;
    if (temp_s8 < TEMP_MIN) begin
      temp_cl  = TEMP_MIN;
      sat_next = 1'b1;
    end else if (temp_s8 > TEMP_MAX) begin
      temp_cl  = TEMP_MAX;
      sat_next = 1'b1;
    end
    if (press < PRESS_MIN) begin
      press_cl = PRESS_MIN;
      sat_next = 1'b1;
    end else if (press > PRESS_MAX) begin
      press_cl = PRESS_MAX;
      sat_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      temp_centi <= TEMP_OUT_W'(temp_cl);
      press_pa   <= PRESS_OUT_W'($unsigned(press_cl));
      saturated  <= sat_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/baro_second_order_compensation.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake               Payload
// in       in_valid / in_ready     raw_temp, raw_press
// out      out_valid / out_ready   temp_centi, press_pa, saturated
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Nine register stages; one transaction per cycle while the output is not stalled.
// Stage depth is set by the 25x25 square of dT and the 24x20 pressure partial products.
// Reset clears the stage valid bits and the six calibration words; no clearing pass.
// A stalled output holds the full stages; empty stages keep taking input.

module baro_second_order_compensation (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic [baro_soc_pkg::RAW_W-1:0]             raw_temp,
  input  logic [baro_soc_pkg::RAW_W-1:0]             raw_press,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic signed [baro_soc_pkg::TEMP_OUT_W-1:0] temp_centi,
  output logic [baro_soc_pkg::PRESS_OUT_W-1:0]       press_pa,
  output logic                                       saturated,
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [baro_soc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [baro_soc_pkg::CAL_W-1:0]             cfg_data
);
  import baro_soc_pkg::*;

  cal_t                  cal;
  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] en;
  first_t                first;
  second_t               second;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_PRESSURE_SENSITIVITY: cal.pressure_sensitivity <= cfg_data;
        REG_PRESSURE_OFFSET:      cal.pressure_offset      <= cfg_data;
        REG_SENS_TEMP_COEFF:      cal.sens_temp_coeff      <= cfg_data;
        REG_OFFSET_TEMP_COEFF:    cal.offset_temp_coeff    <= cfg_data;
        REG_REFERENCE_TEMP:       cal.reference_temp       <= cfg_data;
        REG_TEMP_COEFF:           cal.temp_coeff           <= cfg_data;
        default: ;
      endcase
    end
  end

  // advance a stage when it is empty or its successor advances
  always_comb begin
    en[NUM_STAGES-1] = !valid[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = valid[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  baro_soc_front u_front (
    .clk       (clk),
    .en        (en[2:0]),
    .raw_temp  (raw_temp),
    .raw_press (raw_press),
    .cal       (cal),
    .first     (first)
  );

  baro_soc_second u_second (
    .clk    (clk),
    .en     (en[4:3]),
    .first  (first),
    .second (second)
  );

  baro_soc_press u_press (
    .clk        (clk),
    .en         (en[8:5]),
    .second     (second),
    .temp_centi (temp_centi),
    .press_pa   (press_pa),
    .saturated  (saturated)
  );

endmodule

`default_nettype wire
